/* rtl/core/sdtq_pkg.sv */
// sorted deadline timer queue package: command and status codes, sizes
// no dependencies
package sdtq_pkg;
	localparam int TimerSlots = 32;
	localparam int MaxResults = 32;
	localparam int IdW = 10;
	localparam int DlW = 32;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_EXPIRED  = 3'd1,
		ST_NONE     = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_DUP      = 3'd5
	} status_t;
endpackage

/* rtl/core/sorted_deadline_timer_queue_top.sv */
// sorted deadline timer queue top level: fsm, slot memory, result port
// depends on sdtq_pkg
//
// usage: drive cmd, timer_id, deadline, current_time and raise start; the
// beat is taken on the edge where start is high and busy is low. busy stays
// high until every result of the beat has been sent.
// results come out on status, expired_id, last and occupancy, each for one
// cycle with strobe high; the receiver cannot stall, so no result waits.
// the table lives in one memory of TIMER_SLOTS entries, each a deadline with
// its id, read through a registered output; each slot visit is a read, then a
// compare or a write. the commands run through these steps:
// add: a search pass, a decode, a shift pass over the moved slots, then the
// result. delete: search, then a compaction pass from the found slot.
// adjust: delete, a wait state, then the insert of add.
// tick: a search pass counts the expired timers (at most 32 per beat), then
// pops them one by one: a read of slot 0 and a compaction pass per pop, one
// result per pop, the final one with last set, then a further read of slot 0
// before busy falls. with nothing expired it goes from the search to a result.
// reset clears the count and the control state; the memory is not cleared.
module sorted_deadline_timer_queue_top #(
	parameter int TIMER_SLOTS = sdtq_pkg::TimerSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [9:0]  timer_id,
	input  logic [31:0] deadline,
	input  logic [31:0] current_time,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [9:0]  expired_id,
	output logic        last,
	output logic [5:0]  occupancy
);
	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int EW = sdtq_pkg::DlW + sdtq_pkg::IdW;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SRCH   = 9'b000000010,
		S_SDEC   = 9'b000000100,
		S_RMV    = 9'b000001000,
		S_INS    = 9'b000010000,
		S_TICK   = 9'b000100000,
		S_TDEC   = 9'b001000000,
		S_RESULT = 9'b010000000,
		S_IWAIT  = 9'b100000000
	} state_t;

	state_t          state_q;
	logic [EW-1:0]   mem [TIMER_SLOTS];
	logic [EW-1:0]   rdata_q;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [EW-1:0]   wdata;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;    // walking index
	logic [CW-1:0]   pos_q;    // insert position, found slot or pop count
	logic            found_q;
	logic            pos_set_q;
	logic [1:0]      cmd_q;
	logic [9:0]      id_q;
	logic [31:0]     dl_q;
	logic [31:0]     now_q;
	logic [CW-1:0]   npop_q;
	logic [CW-1:0]   occ_q;    // occupancy after the tick
	logic            rd_pend_q;
	logic [2:0]      st_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	wire [31:0] r_dl = rdata_q[EW-1 -: 32];
	wire [9:0]  r_id = rdata_q[9:0];
	wire        cmd_add = (cmd_q == sdtq_pkg::CMD_ADD);
	wire        cmd_adj = (cmd_q == sdtq_pkg::CMD_ADJUST);
	wire        cmd_tk = (cmd_q == sdtq_pkg::CMD_TICK);
	wire [31:0] key = cmd_tk ? now_q : dl_q;
	wire        pop_cap = (32'(pos_q) > 32'(sdtq_pkg::MaxResults));
	wire [CW-1:0] pop_n = pop_cap ? CW'(sdtq_pkg::MaxResults) : pos_q;

	// read address and write port
	always_comb begin
		raddr = idx_q[AW-1:0];
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata_q;
		unique case (state_q)
			S_RMV: begin
				// copy slot idx+1 into idx; reading idx+1
				raddr = AW'(idx_q + CW'(1));
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = AW'(idx_q - CW'(1));
				end
			end
			S_INS: begin
				// shift down from top: read idx-1, write idx, new entry last
				raddr = AW'(idx_q - CW'(1));
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = AW'(idx_q + CW'(1));
				end else if (idx_q == pos_q) begin
					we = 1'b1;
					wdata = {dl_q, id_q};
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			strobe <= 1'b0;
			rd_pend_q <= 1'b0;
			npop_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						id_q <= timer_id;
						dl_q <= deadline;
						now_q <= current_time;
						idx_q <= '0;
						found_q <= 1'b0;
						pos_set_q <= 1'b0;
						pos_q <= count_q;
						npop_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					// issue read of idx (raddr), evaluate next cycle
					if (idx_q >= count_q) begin
						state_q <= S_SDEC;
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						if (r_id == id_q && !found_q) begin
							found_q <= 1'b1;
							if (!cmd_add && !cmd_tk) pos_q <= idx_q;
						end
						if ((cmd_add || cmd_tk) && !pos_set_q && r_dl > key) begin
							pos_set_q <= 1'b1;
							pos_q <= idx_q;
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				S_SDEC: begin
					rd_pend_q <= 1'b0;
					if (cmd_tk) begin
						if (pos_q == '0) begin
							st_q <= sdtq_pkg::ST_NONE;
							state_q <= S_RESULT;
						end else begin
							pos_q <= pop_n;
							occ_q <= count_q - pop_n;
							idx_q <= '0;
							state_q <= S_TICK;
						end
					end else if (cmd_add) begin
						if (found_q) begin
							st_q <= sdtq_pkg::ST_DUP;
							state_q <= S_RESULT;
						end else if (count_q >= CW'(TIMER_SLOTS)) begin
							st_q <= sdtq_pkg::ST_FULL;
							state_q <= S_RESULT;
						end else begin
							idx_q <= count_q;
							state_q <= S_INS;
						end
					end else if (!found_q) begin
						st_q <= sdtq_pkg::ST_NOTFOUND;
						state_q <= S_RESULT;
					end else begin
						idx_q <= pos_q;
						state_q <= S_RMV;
					end
				end
				S_RMV: begin
					// remove slot pos: move idx+1 down to idx
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (idx_q + CW'(1) >= count_q) begin
						count_q <= count_q - CW'(1);
						if (cmd_tk) begin
							strobe <= 1'b1;
							status <= sdtq_pkg::ST_EXPIRED;
							expired_id <= id_q;
							last <= (npop_q == pos_q);
							occupancy <= 6'(occ_q);
							state_q <= S_TICK;
							idx_q <= '0;
						end else if (cmd_adj) begin
							cmd_q <= sdtq_pkg::CMD_ADD;
							pos_q <= count_q - CW'(1);
							pos_set_q <= 1'b0;
							found_q <= 1'b0;
							idx_q <= '0;
							state_q <= S_IWAIT;
						end else begin
							st_q <= sdtq_pkg::ST_DONE;
							state_q <= S_RESULT;
						end
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end
				end
				S_IWAIT: begin
					// search for insert position only (id is known absent)
					state_q <= S_SRCH;
				end
				S_INS: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (idx_q == pos_q) begin
						count_q <= count_q + CW'(1);
						st_q <= sdtq_pkg::ST_DONE;
						state_q <= S_RESULT;
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= idx_q - CW'(1);
					end
				end
				S_TICK: begin
					// read slot 0
					rd_pend_q <= 1'b0;
					state_q <= S_TDEC;
				end
				S_TDEC: begin
					if (npop_q != pos_q) begin
						npop_q <= npop_q + CW'(1);
						id_q <= r_id;
						idx_q <= '0;
						state_q <= S_RMV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					strobe <= 1'b1;
					status <= st_q;
					expired_id <= '0;
					last <= 1'b1;
					occupancy <= 6'(count_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* bench/sorted_deadline_timer_queue_top_tb.sv */
// self-checking bench for sorted_deadline_timer_queue_top: directed then random commands,
// a scoreboard class predicts the sorted timer table and checks every result beat
// depends on sdtq_pkg and sorted_deadline_timer_queue_top
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_top_tb;

	typedef struct packed {
		sdtq_pkg::status_t st;
		logic [9:0]        id;
		logic              lst;
		logic [5:0]        occ;
	} timer_result_t;

	class timer_scoreboard;
		logic [31:0]   dl_tab[$];
		logic [9:0]    id_tab[$];
		timer_result_t pending[$];
		int            errors;

		function int find_timer(logic [9:0] id);
			for (int i = 0; i < id_tab.size(); i++)
				if (id_tab[i] == id) return i;
			return -1;
		endfunction

		function void insert_timer(logic [9:0] id, logic [31:0] dl);
			int p;
			p = 0;
			while (p < dl_tab.size() && dl_tab[p] <= dl) p++;
			dl_tab.insert(p, dl);
			id_tab.insert(p, id);
		endfunction

		function void note_command(sdtq_pkg::cmd_t c, logic [9:0] id, logic [31:0] dl,
				logic [31:0] now);
			timer_result_t r[$];
			timer_result_t t;
			int p;
			t = '0;
			t.lst = 1'b1;
			case (c)
				sdtq_pkg::CMD_ADD: begin
					if (find_timer(id) >= 0) t.st = sdtq_pkg::ST_DUP;
					else if (id_tab.size() >= sdtq_pkg::TimerSlots) t.st = sdtq_pkg::ST_FULL;
					else begin
						insert_timer(id, dl);
						t.st = sdtq_pkg::ST_DONE;
					end
					r.push_back(t);
				end
				sdtq_pkg::CMD_ADJUST, sdtq_pkg::CMD_DELETE: begin
					p = find_timer(id);
					if (p < 0) t.st = sdtq_pkg::ST_NOTFOUND;
					else begin
						dl_tab.delete(p);
						id_tab.delete(p);
						if (c == sdtq_pkg::CMD_ADJUST) insert_timer(id, dl);
						t.st = sdtq_pkg::ST_DONE;
					end
					r.push_back(t);
				end
				default: begin
					while (r.size() < sdtq_pkg::MaxResults && id_tab.size() > 0
						&& dl_tab[0] <= now) begin
						t.st = sdtq_pkg::ST_EXPIRED;
						t.id = id_tab.pop_front();
						void'(dl_tab.pop_front());
						t.lst = 1'b0;
						r.push_back(t);
					end
					if (r.size() == 0) begin
						t.st = sdtq_pkg::ST_NONE;
						t.lst = 1'b1;
						r.push_back(t);
					end else
						r[r.size() - 1].lst = 1'b1;
				end
			endcase
			foreach (r[k]) begin
				r[k].occ = 6'(id_tab.size());
				pending.push_back(r[k]);
			end
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.st != e.st) begin
				$display("%0t: status exp %0d got %0d", $time, e.st, got.st);
				errors++;
			end
			if (got.id != e.id) begin
				$display("%0t: expired_id exp %0d got %0d", $time, e.id, got.id);
				errors++;
			end
			if (got.lst != e.lst) begin
				$display("%0t: last exp %0d got %0d", $time, e.lst, got.lst);
				errors++;
			end
			if (got.occ != e.occ) begin
				$display("%0t: occupancy exp %0d got %0d", $time, e.occ, got.occ);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [9:0]  timer_id;
	logic [31:0] deadline;
	logic [31:0] current_time;
	logic        strobe;
	logic [2:0]  status;
	logic [9:0]  expired_id;
	logic        last;
	logic [5:0]  occupancy;

	timer_scoreboard sb;
	int idle_pct;
	int quiet_cycles;

	sorted_deadline_timer_queue_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.timer_id(timer_id), .deadline(deadline), .current_time(current_time),
		.strobe(strobe), .status(status), .expired_id(expired_id), .last(last),
		.occupancy(occupancy)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(timer_result_t'{sdtq_pkg::status_t'(status), expired_id, last,
				occupancy});
	end

	// watchdog on beats in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("sorted_deadline_timer_queue_top regression: fail");
			$finish;
		end
	end

	task automatic send_command(sdtq_pkg::cmd_t c, logic [9:0] id, logic [31:0] dl,
			logic [31:0] now);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		timer_id <= id;
		deadline <= dl;
		current_time <= now;
		do @(posedge clk); while (busy);
		sb.note_command(c, id, dl, now);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [9:0] pick_id();
		if (sb.id_tab.size() > 0 && $urandom_range(3) != 0)
			return sb.id_tab[$urandom_range(sb.id_tab.size() - 1)];
		return 10'($urandom);
	endfunction

	initial begin
		logic [31:0] base;
		int r;
		sb = new();
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = sdtq_pkg::CMD_ADD;
		timer_id = '0;
		deadline = '0;
		current_time = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, errors, ties, empty tick
		send_command(sdtq_pkg::CMD_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF);
		send_command(sdtq_pkg::CMD_ADD, 10'd1023, 32'hFFFF_FFFF, 32'd0);
		send_command(sdtq_pkg::CMD_ADD, 10'd0, 32'd0, 32'd0);
		send_command(sdtq_pkg::CMD_ADD, 10'd0, 32'd5, 32'd0);
		send_command(sdtq_pkg::CMD_ADD, 10'd5, 32'd100, 32'd0);
		send_command(sdtq_pkg::CMD_ADD, 10'd6, 32'd100, 32'd0);
		send_command(sdtq_pkg::CMD_ADJUST, 10'd5, 32'd100, 32'd0);
		send_command(sdtq_pkg::CMD_ADJUST, 10'd1023, 32'd1, 32'd0);
		send_command(sdtq_pkg::CMD_ADJUST, 10'd77, 32'd1, 32'd0);
		send_command(sdtq_pkg::CMD_DELETE, 10'd77, 32'd0, 32'd0);
		send_command(sdtq_pkg::CMD_DELETE, 10'd0, 32'd0, 32'd0);
		send_command(sdtq_pkg::CMD_TICK, 10'd0, 32'd0, 32'd99);
		send_command(sdtq_pkg::CMD_TICK, 10'd0, 32'd0, 32'd100);
		for (int i = 0; i < 33; i++)
			send_command(sdtq_pkg::CMD_ADD, 10'(200 + i), 32'(i % 3), 32'd0);
		send_command(sdtq_pkg::CMD_ADD, 10'd200, 32'd0, 32'd0);
		send_command(sdtq_pkg::CMD_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF);
		send_command(sdtq_pkg::CMD_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 54 : (ph == 3 ? 12 : 0);
			base = (ph == 2) ? 32'hFFFF_FF00 : 32'($urandom_range(1000));
			for (int n = 0; n < 38; n++) begin
				r = $urandom_range(99);
				if (r < 40)
					send_command(sdtq_pkg::CMD_ADD, pick_id(),
						($urandom_range(9) == 0) ? 32'($urandom) : base + $urandom_range(60),
						32'($urandom));
				else if (r < 60)
					send_command(sdtq_pkg::CMD_ADJUST, pick_id(), base + $urandom_range(60),
						32'($urandom));
				else if (r < 75)
					send_command(sdtq_pkg::CMD_DELETE, pick_id(), 32'($urandom),
						32'($urandom));
				else
					send_command(sdtq_pkg::CMD_TICK, 10'($urandom), 32'($urandom),
						($urandom_range(9) == 0) ? 32'($urandom) : base + $urandom_range(40));
				if (n == 19) drain_results();
			end
			drain_results();
		end

		drain_results();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sorted_deadline_timer_queue_top regression: pass");
		else
			$display("sorted_deadline_timer_queue_top regression: fail");
		$finish;
	end
endmodule

/* files.f */
rtl/core/sdtq_pkg.sv
rtl/core/sorted_deadline_timer_queue_top.sv
bench/sorted_deadline_timer_queue_top_tb.sv
